// ===== sv/sha_pkg.sv =====
// Package: payload types, queue types, SHA-256 constants and round functions.
package sha_pkg;

	typedef struct packed {
		logic       mode;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_item_t;

	localparam logic MODE_ABSORB = 1'b0;
	localparam logic MODE_FINISH = 1'b1;

	// Command passed from the front part to the round engine.
	typedef struct packed {
		logic [511:0] block;
		logic         emit;  // final block of a message: emit digest, reset state
	} blk_cmd_t;

	localparam int QDEPTH = 2;

	typedef enum logic [1:0] {
		FS_COLLECT,
		FS_PAD2,
		FS_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		BS_IDLE,
		BS_ROUND,
		BS_EMIT
	} back_state_t;

	localparam logic [255:0] H_INIT = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	function automatic logic [31:0] ror32(input logic [31:0] v, input int s);
		return (v >> s) | (v << (32 - s));
	endfunction

	function automatic logic [31:0] sig0(input logic [31:0] w);
		return ror32(w, 7) ^ ror32(w, 18) ^ (w >> 3);
	endfunction

	function automatic logic [31:0] sig1(input logic [31:0] w);
		return ror32(w, 17) ^ ror32(w, 19) ^ (w >> 10);
	endfunction

	function automatic logic [31:0] bsig0(input logic [31:0] a);
		return ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22);
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] e);
		return ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25);
	endfunction

endpackage

// ===== sv/sha_front.sv =====
// Front part: accepts bytes, builds blocks, applies padding, pushes block commands.
module sha_front import sha_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  in_item_t in_data,
	input  logic     in_valid,
	output logic     in_ready,
	output blk_cmd_t cmd,
	output logic     cmd_valid,
	input  logic     cmd_ready
);

	front_state_t state_q, state_nx;
	logic [511:0] buf_q;
	logic [5:0]   fill_q;
	logic [63:0]  bits_q;
	blk_cmd_t     cmd_q;
	logic [511:0] padded;
	logic [63:0]  total;

	assign total = bits_q + {55'd0, fill_q, 3'd0};

	// Padded first block for a finish: 0x80 at the fill position, zero after it,
	// and the length in the tail when it fits.
	always_comb begin
		padded = buf_q;
		for (int i = 0; i < 64; i++) begin
			if (i == fill_q) padded[511 - 8*i -: 8] = 8'h80;
			else if (i > fill_q) padded[511 - 8*i -: 8] = 8'h00;
		end
		if (fill_q < 6'd56) padded[63:0] = total;
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			FS_COLLECT: if (in_valid && in_ready) begin
				if (in_data.mode == MODE_FINISH && fill_q >= 6'd56) state_nx = FS_PAD2;
				else if (in_data.mode == MODE_FINISH || fill_q == 6'd63) state_nx = FS_PUSH;
			end
			FS_PUSH: if (cmd_ready) state_nx = FS_COLLECT;
			FS_PAD2: if (cmd_ready) state_nx = FS_PUSH;
			default: state_nx = FS_COLLECT;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == FS_COLLECT);
		cmd_valid = (state_q == FS_PUSH) || (state_q == FS_PAD2);
		cmd       = cmd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_COLLECT;
			fill_q  <= '0;
			bits_q  <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == FS_COLLECT && in_valid) begin
				if (in_data.mode == MODE_ABSORB) begin
					fill_q <= fill_q + 6'd1;
					if (fill_q == 6'd63) bits_q <= bits_q + 64'd512;
				end else begin
					fill_q <= '0;
					bits_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == FS_COLLECT && in_valid) begin
			if (in_data.mode == MODE_ABSORB) begin
				buf_q[511 - 8*fill_q -: 8] <= in_data.data_byte;
				if (fill_q == 6'd63)
					cmd_q <= '{block: {buf_q[511:8], in_data.data_byte}, emit: 1'b0};
			end else begin
				cmd_q <= '{block: padded, emit: (fill_q < 6'd56)};
				buf_q <= {448'd0, total};
			end
		end else if (state_q == FS_PAD2 && cmd_ready) begin
			cmd_q <= '{block: buf_q, emit: 1'b1};
		end
	end

endmodule

// ===== sv/sha_queue.sv =====
// Short queue of block commands between the front part and the round engine.
module sha_queue import sha_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  blk_cmd_t wr_data,
	input  logic     wr_valid,
	output logic     wr_ready,
	output blk_cmd_t rd_data,
	output logic     rd_valid,
	input  logic     rd_ready
);

	localparam int PW = $clog2(QDEPTH);
	blk_cmd_t        mem_q [QDEPTH];
	logic [PW-1:0]   wp_q, rp_q;
	logic [PW:0]     cnt_q;
	logic            push, pop;

	assign wr_ready = (cnt_q != (PW+1)'(QDEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = mem_q[rp_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_data;
	end

endmodule

// ===== sv/sha_back.sv =====
// Round engine: one compression round per cycle, digest emission from the hash register.
module sha_back import sha_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  blk_cmd_t  cmd,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	output out_item_t out_data,
	output logic      out_valid,
	input  logic      out_ready
);

	back_state_t  state_q, state_nx;
	logic [255:0] hash_q;
	logic [31:0]  w_q [16];
	logic [31:0]  a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;
	logic [5:0]   rnd_q;
	logic         emit_q;
	logic [2:0]   idx_q;
	logic [31:0]  wv, t1, t2, wnew;

	// Window holds W[r..r+15]; W[r] is at slot 0.
	assign wv   = w_q[0];
	assign wnew = sig1(w_q[14]) + w_q[9] + sig0(w_q[1]) + w_q[0];
	assign t1   = h_q + bsig1(e_q) + ((e_q & f_q) ^ (~e_q & g_q)) + ROUND_K[rnd_q] + wv;
	assign t2   = bsig0(a_q) + ((a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q));

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			BS_IDLE:  if (cmd_valid) state_nx = BS_ROUND;
			BS_ROUND: if (rnd_q == 6'd63) state_nx = emit_q ? BS_EMIT : BS_IDLE;
			BS_EMIT:  if (out_ready && idx_q == 3'd7) state_nx = BS_IDLE;
			default:  state_nx = BS_IDLE;
		endcase
	end

	always_comb begin
		cmd_ready = (state_q == BS_IDLE);
		out_valid = (state_q == BS_EMIT);
		out_data  = '{digest_word: hash_q[255 - 32*idx_q -: 32], word_index: idx_q,
			last_word: (idx_q == 3'd7)};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BS_IDLE;
			hash_q  <= H_INIT;
			rnd_q   <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_nx;
			unique case (state_q)
				BS_IDLE: rnd_q <= '0;
				BS_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						hash_q <= {hash_q[255:224] + t1 + t2, hash_q[223:192] + a_q,
							hash_q[191:160] + b_q, hash_q[159:128] + c_q,
							hash_q[127:96] + d_q + t1, hash_q[95:64] + e_q,
							hash_q[63:32] + f_q, hash_q[31:0] + g_q};
						idx_q <= '0;
					end
				end
				BS_EMIT: if (out_ready) begin
					idx_q <= idx_q + 3'd1;
					if (idx_q == 3'd7) hash_q <= H_INIT;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == BS_IDLE && cmd_valid) begin
			for (int i = 0; i < 16; i++) w_q[i] <= cmd.block[511 - 32*i -: 32];
			{a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q} <= hash_q;
			emit_q <= cmd.emit;
		end else if (state_q == BS_ROUND) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wnew;
			h_q <= g_q; g_q <= f_q; f_q <= e_q; e_q <= d_q + t1;
			d_q <= c_q; c_q <= b_q; b_q <= a_q; a_q <= t1 + t2;
		end
	end

endmodule

// ===== sv/sha256_stream_hasher.sv =====
// Top level: streaming SHA-256 engine, front part, command queue and round engine.
//
//  channel  | signals                          | payload
//  in       | in_valid / in_ready  / in_data   | in_item_t  (mode, data_byte)
//  out      | out_valid / out_ready / out_data | out_item_t (digest_word, word_index, last_word)
//
// One byte is taken per cycle while collecting; every 64th byte and every finish
// hands its block to the queue in the push state (pad2 first for a two-block pad);
// no byte is taken until the queue accepts. The round engine loads each block and
// runs 64 rounds, so long messages run at about one byte per cycle (single-round datapath).
// A digest takes eight out transactions; out_ready low holds the engine.
// Reset loads the initial hash values and empties fill, length and queue.
module sha256_stream_hasher import sha_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  in_data,
	input  logic      in_valid,
	output logic      in_ready,
	output out_item_t out_data,
	output logic      out_valid,
	input  logic      out_ready
);

	blk_cmd_t f_cmd, q_cmd;
	logic     f_valid, f_ready, q_valid, q_ready;

	// Collect bytes and pad finished messages.
	sha_front u_front (
		.clk, .arst_n, .in_data, .in_valid, .in_ready,
		.cmd(f_cmd), .cmd_valid(f_valid), .cmd_ready(f_ready)
	);

	// Decouple collection from the rounds.
	sha_queue u_queue (
		.clk, .arst_n,
		.wr_data(f_cmd), .wr_valid(f_valid), .wr_ready(f_ready),
		.rd_data(q_cmd), .rd_valid(q_valid), .rd_ready(q_ready)
	);

	// Run compression and emit the digest.
	sha_back u_back (
		.clk, .arst_n, .cmd(q_cmd), .cmd_valid(q_valid), .cmd_ready(q_ready),
		.out_data, .out_valid, .out_ready
	);

endmodule

// ===== sv/sha_checker.sv =====
// Checker: port-level properties of the hasher, bound to the top level.
module sha_checker import sha_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input in_item_t  in_data,
	input logic      in_valid,
	input logic      in_ready,
	input out_item_t out_data,
	input logic      out_valid,
	input logic      out_ready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("out payload changed while stalled");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.last_word == (out_data.word_index == 3'd7)))
		else $error("last_word does not match index");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_data.last_word |=>
			out_valid && out_data.word_index == $past(out_data.word_index) + 3'd1)
		else $error("digest words out of order");

	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> out_data.word_index == 3'd0)
		else $error("digest does not start at word 0");

endmodule

bind sha256_stream_hasher sha_checker u_sha_checker (.*);

// ===== test/sha256_stream_hasher_tb.sv =====
// Testbench for the streaming SHA-256 hasher: directed and random traffic checked against a local digest model.
`timescale 1ns / 100ps

module sha256_stream_hasher_tb;
	import sha_pkg::*;

	logic      clk;
	logic      arst_n;
	in_item_t  in_data;
	logic      in_valid;
	logic      in_ready;
	out_item_t out_data;
	logic      out_valid;
	logic      out_ready;

	sha256_stream_hasher dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_data (out_data),
		.out_valid(out_valid),
		.out_ready(out_ready)
	);

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_OFF_CYCLES = 600;

	// Round constants and initial hash, kept local to the digest model.
	localparam logic [31:0] K_TAB [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
	localparam logic [31:0] IV_TAB [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	// Model state: running hash, partial block, bit count of full blocks.
	logic [31:0] mdl_hash [8];
	logic [7:0]  mdl_block [64];
	logic [5:0]  mdl_fill;
	logic [63:0] mdl_bits;

	in_item_t  pending_items [$];
	out_item_t expected_words [$];

	int  mismatches = 0;
	bit  quiet_phase;   // last part of the run: no random idle bursts are started on either side
	int  idle_cycles;

	function automatic logic [31:0] rotr(input logic [31:0] v, input int s);
		return (v >> s) | (v << (32 - s));
	endfunction

	task automatic compress_model();
		logic [31:0] w [16];
		logic [31:0] a, b, c, d, e, f, g, h, wv, t1, t2, w15, w2;
		a = mdl_hash[0]; b = mdl_hash[1]; c = mdl_hash[2]; d = mdl_hash[3];
		e = mdl_hash[4]; f = mdl_hash[5]; g = mdl_hash[6]; h = mdl_hash[7];
		for (int r = 0; r < 16; r++)
			w[r] = {mdl_block[4*r], mdl_block[4*r+1], mdl_block[4*r+2], mdl_block[4*r+3]};
		for (int r = 0; r < 64; r++) begin
			if (r < 16) begin
				wv = w[r];
			end else begin
				w15 = w[(r - 15) & 15];
				w2  = w[(r - 2) & 15];
				wv = w[r & 15] + (rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3))
					+ w[(r - 7) & 15] + (rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10));
				w[r & 15] = wv;
			end
			t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
				+ K_TAB[r] + wv;
			t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		mdl_hash[0] += a; mdl_hash[1] += b; mdl_hash[2] += c; mdl_hash[3] += d;
		mdl_hash[4] += e; mdl_hash[5] += f; mdl_hash[6] += g; mdl_hash[7] += h;
	endtask

	task automatic restart_model();
		for (int i = 0; i < 8; i++)
			mdl_hash[i] = IV_TAB[i];
		mdl_fill = '0;
		mdl_bits = '0;
	endtask

	// Advance the model by one accepted transaction; queue the digest on finish.
	task automatic absorb_or_finish(input in_item_t it);
		int pos;
		logic [63:0] total;
		out_item_t o;
		if (it.mode == MODE_ABSORB) begin
			mdl_block[mdl_fill] = it.data_byte;
			mdl_fill = mdl_fill + 6'd1;
			if (mdl_fill == 0) begin
				compress_model();
				mdl_bits = mdl_bits + 64'd512;
			end
		end else begin
			pos = mdl_fill;
			total = mdl_bits + 64'(pos) * 64'd8;
			mdl_block[pos] = 8'h80;
			pos++;
			if (pos > 56) begin
				while (pos < 64) begin
					mdl_block[pos] = 8'h00;
					pos++;
				end
				compress_model();
				pos = 0;
			end
			while (pos < 56) begin
				mdl_block[pos] = 8'h00;
				pos++;
			end
			for (int i = 0; i < 8; i++)
				mdl_block[56 + i] = total[63 - 8*i -: 8];
			compress_model();
			for (int i = 0; i < 8; i++) begin
				o.digest_word = mdl_hash[i];
				o.word_index = 3'(i);
				o.last_word = (i == 7);
				expected_words = {expected_words, o};
			end
			restart_model();
		end
	endtask

	task automatic add_bytes(input int n);
		in_item_t it;
		for (int i = 0; i < n; i++) begin
			it.mode = MODE_ABSORB;
			it.data_byte = 8'($urandom);
			pending_items = {pending_items, it};
		end
	endtask

	task automatic add_finish();
		in_item_t it;
		it.mode = MODE_FINISH;
		it.data_byte = 8'($urandom);  // ignored by the block
		pending_items = {pending_items, it};
	endtask

	task automatic add_const_bytes(input int n, input logic [7:0] v);
		in_item_t it;
		for (int i = 0; i < n; i++) begin
			it.mode = MODE_ABSORB;
			it.data_byte = v;
			pending_items = {pending_items, it};
		end
	endtask

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	// Driver: offer pending items, with random idle bursts between transactions.
	int drv_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
			drv_gap  <= 0;
		end else begin
			if (in_valid && in_ready) begin
				absorb_or_finish(in_data);
			end
			if (in_valid && !in_ready) begin
				// hold the offered transaction until accepted
			end else if (drv_gap > 0) begin
				in_valid <= 1'b0;
				drv_gap <= drv_gap - 1;
			end else if (!quiet_phase && $urandom_range(0, 15) == 0) begin
				in_valid <= 1'b0;
				drv_gap <= $urandom_range(0, 11);
			end else if (pending_items.size() > 0) begin
				in_valid <= 1'b1;
				in_data <= pending_items.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: check each out transaction against the oldest expected word.
	// Hold off once right after reset so the engine and the queue fill up.
	int mon_gap;
	int hold_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			mon_gap   <= 0;
			hold_left <= HOLD_OFF_CYCLES;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected out transaction: %h idx %0d last %0b",
							out_data.digest_word, out_data.word_index, out_data.last_word);
				end else begin
					out_item_t ex;
					ex = expected_words.pop_front();
					if (ex !== out_data) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %h idx %0d last %0b, %s",
								ex.digest_word, ex.word_index, ex.last_word,
								$sformatf("got %h idx %0d last %0b", out_data.digest_word,
									out_data.word_index, out_data.last_word));
					end
				end
			end
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= (hold_left == 1);
			end else if (mon_gap > 0) begin
				mon_gap <= mon_gap - 1;
				out_ready <= (mon_gap == 1);
			end else if (!quiet_phase && $urandom_range(0, 15) == 0) begin
				mon_gap <= $urandom_range(1, 12);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog: count cycles with no transaction on either channel.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int len;
		arst_n = 1'b0;
		quiet_phase = 1'b0;
		for (int i = 0; i < 64; i++)
			mdl_block[i] = 8'h00;
		restart_model();

		// Directed: empty message, byte extremes, pad boundaries at 55, 56 and 64 bytes.
		add_finish();
		add_const_bytes(1, 8'h00); add_finish();
		add_const_bytes(1, 8'hff); add_finish();
		add_const_bytes(3, 8'h61); add_finish();
		add_bytes(55); add_finish();
		add_bytes(56); add_finish();
		add_finish();
		add_bytes(64); add_finish();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Short messages queued behind the receiver hold-off.
		for (int m = 0; m < 4; m++) begin
			add_bytes($urandom_range(0, 20)); add_finish();
		end

		// Random messages: mostly short, a few spanning two blocks.
		for (int m = 0; m < 5; m++) begin
			if ($urandom_range(0, 4) == 0)
				len = $urandom_range(57, 100);
			else
				len = $urandom_range(0, 40);
			add_bytes(len);
			add_finish();
		end

		wait (pending_items.size() == 0);
		quiet_phase = 1'b1;
		for (int m = 0; m < 4; m++) begin
			add_bytes($urandom_range(0, 40)); add_finish();
		end
		wait (pending_items.size() == 0 && !in_valid);
		wait (expected_words.size() == 0);
		repeat (200) @(posedge clk);
		if (mismatches == 0 && expected_words.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
